[rtl/sha512_pkg.sv]
// Shared types, constants and round functions for the SHA-512 engine.
package sha512_pkg;

    localparam int unsigned QDepth  = 4;
    localparam int unsigned QPtrW   = 2;
    localparam logic [6:0]  PadStop = 7'd111;   // last fill position before the length field

    // Front-end states: idle/byte intake, then the three padding phases
    typedef enum logic [1:0] {
        F_IDLE,
        F_PAD80,
        F_PADZ,
        F_PADLEN
    } t_front_state;

    // Back-end states
    typedef enum logic [1:0] {
        B_LOAD,
        B_ROUND,
        B_ADD,
        B_OUT
    } t_back_state;

    // One queued request: a big-endian message word, final marks end of the last block
    typedef struct packed {
        logic        final_blk;
        logic [63:0] word;
    } t_q_item;

    // Queue status seen by the front end
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [63:0] f_iv(input logic [2:0] idx);
        logic [63:0] v;
        case (idx)
            3'd0:    v = 64'h6a09e667f3bcc908;
            3'd1:    v = 64'hbb67ae8584caa73b;
            3'd2:    v = 64'h3c6ef372fe94f82b;
            3'd3:    v = 64'ha54ff53a5f1d36f1;
            3'd4:    v = 64'h510e527fade682d1;
            3'd5:    v = 64'h9b05688c2b3e6c1f;
            3'd6:    v = 64'h1f83d9abfb41bd6b;
            default: v = 64'h5be0cd19137e2179;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] f_k(input logic [6:0] idx);
        logic [63:0] k;
        case (idx)
            7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'h0;
        endcase
        return k;
    endfunction

    function automatic logic [63:0] f_bsig0(input logic [63:0] x);
        return {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
    endfunction

    function automatic logic [63:0] f_bsig1(input logic [63:0] x);
        return {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
    endfunction

    function automatic logic [63:0] f_ssig0(input logic [63:0] x);
        return {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ (x >> 7);
    endfunction

    function automatic logic [63:0] f_ssig1(input logic [63:0] x);
        return {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ (x >> 6);
    endfunction

endpackage

[rtl/sha512_queue.sv]
// Small word queue between the byte front end and the compression core.
module sha512_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sha512_pkg::t_q_item i_item,
    input  logic                i_pop,
    output sha512_pkg::t_q_item o_item,
    output sha512_pkg::t_q_status o_status
);
    import sha512_pkg::*;

    t_q_item            r_mem [QDepth];
    logic [QPtrW-1:0]   r_wr_ptr;
    logic [QPtrW-1:0]   r_rd_ptr;
    logic [QPtrW:0]     r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_item         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == (QPtrW+1)'(QDepth));
    assign o_status.empty = (r_count == '0);

endmodule

[rtl/sha512_front.sv]
// Byte intake, word packing, bit counting and message padding.
module sha512_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_byte,
    input  logic                  i_has_byte,
    input  logic                  i_last,
    input  sha512_pkg::t_q_status i_q_status,
    output logic                  o_push,
    output sha512_pkg::t_q_item   o_item
);
    import sha512_pkg::*;

    t_front_state r_state, n_state;
    logic [55:0]  r_word;
    logic [6:0]   r_fill;
    logic [127:0] r_bit_cnt;
    logic [3:0]   r_len_idx;

    logic         accept;
    logic         emit;
    logic [7:0]   emit_byte;
    logic [7:0]   len_byte;

    assign len_byte = 8'(r_bit_cnt >> {~r_len_idx, 3'b000});
    assign accept   = i_valid && o_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:   if (accept && i_last) n_state = F_PAD80;
            F_PAD80:  if (emit) n_state = (r_fill == PadStop) ? F_PADLEN : F_PADZ;
            F_PADZ:   if (emit && r_fill == PadStop) n_state = F_PADLEN;
            F_PADLEN: if (emit && r_len_idx == 4'hf) n_state = F_IDLE;
            default:  n_state = F_IDLE;
        endcase
    end

    // byte source and handshake
    always_comb begin
        o_ready   = 1'b0;
        emit      = 1'b0;
        emit_byte = 8'h00;
        case (r_state)
            F_IDLE: begin
                o_ready   = !i_q_status.full;
                emit      = i_valid && !i_q_status.full && i_has_byte;
                emit_byte = i_byte;
            end
            F_PAD80: begin
                emit      = !i_q_status.full;
                emit_byte = 8'h80;
            end
            F_PADZ: begin
                emit      = !i_q_status.full;
            end
            F_PADLEN: begin
                emit      = !i_q_status.full;
                emit_byte = len_byte;
            end
            default: ;
        endcase
    end

    // a word is pushed when its eighth byte arrives
    assign o_push           = emit && (r_fill[2:0] == 3'd7);
    assign o_item.word      = {r_word, emit_byte};
    assign o_item.final_blk = (r_state == F_PADLEN) && (r_len_idx == 4'hf);

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_word <= {r_word[47:0], emit_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_fill    <= '0;
            r_bit_cnt <= '0;
            r_len_idx <= '0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_fill <= r_fill + 1'b1;
            end
            if (r_state == F_IDLE && emit) begin
                r_bit_cnt <= r_bit_cnt + 128'd8;
            end
            if (r_state == F_PADLEN && emit) begin
                r_len_idx <= r_len_idx + 1'b1;
                // message done: length restarts for the next one
                if (r_len_idx == 4'hf) begin
                    r_bit_cnt <= '0;
                end
            end
        end
    end

endmodule

[rtl/sha512_core.sv]
// Compression core: message schedule, 80 rounds, chaining update, digest output.
module sha512_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha512_pkg::t_q_item i_item,
    input  logic                i_q_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [63:0]         o_word,
    output logic [2:0]          o_index,
    output logic                o_end
);
    import sha512_pkg::*;

    t_back_state r_state, n_state;
    logic [63:0] r_h [8];
    logic [63:0] r_v [8];
    logic [63:0] r_w [16];
    logic [6:0]  r_cnt;
    logic        r_final;
    logic [2:0]  r_out_idx;

    logic [63:0] t1, t2, w_new, ch, maj;

    assign ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1    = r_v[7] + f_bsig1(r_v[4]) + ch + f_k(r_cnt) + r_w[0];
    assign t2    = f_bsig0(r_v[0]) + maj;
    assign w_new = f_ssig1(r_w[14]) + r_w[9] + f_ssig0(r_w[1]) + r_w[0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_LOAD:  if (!i_q_empty && r_cnt == 7'd15) n_state = B_ROUND;
            B_ROUND: if (r_cnt == 7'd79) n_state = B_ADD;
            B_ADD:   n_state = r_final ? B_OUT : B_LOAD;
            B_OUT:   if (i_ready && r_out_idx == 3'd7) n_state = B_LOAD;
            default: n_state = B_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        o_pop   = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            B_LOAD:  o_pop   = !i_q_empty;
            B_OUT:   o_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_word  = r_h[r_out_idx];
    assign o_index = r_out_idx;
    assign o_end   = (r_out_idx == 3'd7);

    // schedule window and working variables
    always_ff @(posedge i_clk) begin
        if (r_state == B_LOAD && !i_q_empty) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= i_item.word;
            r_final <= i_item.final_blk;
            if (r_cnt == 7'd15) begin
                for (int i = 0; i < 8; i++) begin
                    r_v[i] <= r_h[i];
                end
            end
        end
        if (r_state == B_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    // control and chaining words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_LOAD;
            r_cnt     <= '0;
            r_out_idx <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= f_iv(3'(i));
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                B_LOAD: begin
                    if (!i_q_empty) begin
                        r_cnt <= (r_cnt == 7'd15) ? 7'd0 : r_cnt + 1'b1;
                    end
                end
                B_ROUND: begin
                    r_cnt <= (r_cnt == 7'd79) ? 7'd0 : r_cnt + 1'b1;
                end
                B_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    r_out_idx <= '0;
                end
                B_OUT: begin
                    if (i_ready) begin
                        r_out_idx <= r_out_idx + 1'b1;
                        if (r_out_idx == 3'd7) begin
                            for (int i = 0; i < 8; i++) begin
                                r_h[i] <= f_iv(3'(i));
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

[rtl/sha512_hash_engine.sv]
// Top level of the SHA-512 engine: front end, word queue and compression core.
// Throughput: one byte per cycle while the queue has room and no padding runs; the
//   core compresses a 128-byte block in 16 word loads, 80 rounds and 1 chaining add.
// After the closing request: padding runs one byte per cycle while the queue has room,
//   then the last compression, then eight digest words, one per cycle unless stalled.
// Reset (i_rst_n low, synchronous): clears fill, bit count and queue, loads the IV.
module sha512_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] has_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [63:0] digest_word
    output logic [2:0]  o_m_axis_tuser,   // [2:0] word_index
    output logic        o_m_axis_tlast
);
    import sha512_pkg::*;

    t_q_item   push_item;
    t_q_item   head_item;
    t_q_status q_status;
    logic      push;
    logic      pop;

    sha512_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_byte     (i_s_axis_tdata),
        .i_has_byte (i_s_axis_tuser),
        .i_last     (i_s_axis_tlast),
        .i_q_status (q_status),
        .o_push     (push),
        .o_item     (push_item)
    );

    sha512_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (q_status)
    );

    sha512_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (head_item),
        .i_q_empty (q_status.empty),
        .o_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_word    (o_m_axis_tdata),
        .o_index   (o_m_axis_tuser),
        .o_end     (o_m_axis_tlast)
    );

endmodule

[bench/tb_top.sv]
// Self-checking bench for the SHA-512 byte-stream hash engine.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Expected digest word, held until the engine returns it
    typedef struct {
        logic [63:0] word;
        logic [2:0]  idx;
        logic        fin;
    } t_digest_exp;

    // Byte-level SHA-512 predictor plus queue of pending digest words
    class digest_scoreboard;
        logic [63:0] hstate [8];
        logic [7:0]  blk [128];
        int unsigned fill;
        logic [127:0] nbits;
        t_digest_exp pending [$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
            restart();
            foreach (blk[i]) blk[i] = 8'h00;
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++) hstate[i] = iv_word(i);
            fill = 0;
            nbits = '0;
        endfunction

        function logic [63:0] iv_word(int i);
            logic [63:0] t [8];
            t = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
                  64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
                  64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
            return t[i];
        endfunction

        function logic [63:0] rot(logic [63:0] x, int n);
            return (x >> n) | (x << (64 - n));
        endfunction

        function void compress();
            logic [63:0] kc [80];
            logic [63:0] w [80];
            logic [63:0] v [8];
            logic [63:0] t1, t2, e, a;
            kc = '{
            64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
            64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
            64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
            64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
            64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
            64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
            64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
            64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
            64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
            64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
            64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
            64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
            64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
            64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
            64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
            64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
            64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
            64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
            64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
            64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
            for (int i = 0; i < 16; i++)
                w[i] = {blk[8*i], blk[8*i+1], blk[8*i+2], blk[8*i+3],
                        blk[8*i+4], blk[8*i+5], blk[8*i+6], blk[8*i+7]};
            for (int i = 16; i < 80; i++)
                w[i] = (rot(w[i-2], 19) ^ rot(w[i-2], 61) ^ (w[i-2] >> 6)) + w[i-7]
                     + (rot(w[i-15], 1) ^ rot(w[i-15], 8) ^ (w[i-15] >> 7)) + w[i-16];
            for (int i = 0; i < 8; i++) v[i] = hstate[i];
            for (int i = 0; i < 80; i++) begin
                e = v[4];
                a = v[0];
                t1 = v[7] + (rot(e, 14) ^ rot(e, 18) ^ rot(e, 41)) + ((e & v[5]) ^ (~e & v[6]))
                   + kc[i] + w[i];
                t2 = (rot(a, 28) ^ rot(a, 34) ^ rot(a, 39))
                   + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) hstate[i] += v[i];
        endfunction

        // Accepted input request: absorb byte, finish message on last
        function void note_request(logic [7:0] b, logic has, logic lst);
            t_digest_exp x;
            int unsigned pos;
            if (has) begin
                blk[fill] = b;
                nbits += 128'd8;
                fill++;
                if (fill == 128) begin
                    compress();
                    fill = 0;
                end
            end
            if (!lst) return;
            pos = fill;
            blk[pos] = 8'h80;
            pos++;
            if (pos > 112) begin
                for (int i = pos; i < 128; i++) blk[i] = 8'h00;
                compress();
                pos = 0;
            end
            for (int i = pos; i < 112; i++) blk[i] = 8'h00;
            for (int i = 0; i < 16; i++) blk[112+i] = nbits[127-8*i -: 8];
            compress();
            for (int k = 0; k < 8; k++) begin
                x.word = hstate[k];
                x.idx = k[2:0];
                x.fin = (k == 7);
                pending.push_back(x);
            end
            restart();
        endfunction

        // Returned digest word against the oldest expectation
        function void check_word(logic [63:0] wd, logic [2:0] ix, logic fn);
            t_digest_exp x;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected digest word %h", wd);
                return;
            end
            x = pending.pop_front();
            if (wd !== x.word || ix !== x.idx || fn !== x.fin) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("digest mismatch: exp %h idx %0d end %b, got %h idx %0d end %b",
                             x.word, x.idx, x.fin, wd, ix, fn);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data = '0;
    logic        s_user = 1'b0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_data;
    logic [2:0]  m_user;
    logic        m_last;

    digest_scoreboard sb;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    always #4 i_clk = ~i_clk;

    sha512_hash_engine DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user), .i_s_axis_tlast(s_last),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user), .o_m_axis_tlast(m_last)
    );

    // Sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_valid && s_ready) sb.note_request(s_data, s_user, s_last);
            if (m_valid && m_ready) sb.check_word(m_data, m_user, m_last);
        end
    end

    // Receiver back-pressure, changed at the falling edge
    always @(negedge i_clk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    // One input request, held until accepted; valid drops only in idle cycles
    task automatic send_request(logic [7:0] b, logic has, logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_user  <= has;
        s_last  <= lst;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_message(int unsigned len, logic close_alone);
        for (int i = 0; i < len; i++)
            send_request(8'($urandom_range(255)), 1'b1, !close_alone && i == len - 1);
        if (close_alone || len == 0) send_request(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    initial begin
        sb = new();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // No idling: empty message, single bytes at the extremes, padding edge
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'hff, 1'b1, 1'b1);
        send_request(8'h00, 1'b1, 1'b1);
        send_request(8'ha5, 1'b0, 1'b0);   // ignored
        send_request(8'h5a, 1'b1, 1'b0);
        send_request(8'h3c, 1'b0, 1'b1);
        send_message(3, 1'b0);
        send_message(111, 1'b0);
        // Sender idling: length that needs a second padding block
        send_idle_pct = 52;
        send_message(112, 1'b1);
        // Receiver stalling, then both sides idling
        for (int ph = 2; ph < 4; ph++) begin
            send_idle_pct  = (ph == 3) ? 29 : 0;
            recv_stall_pct = (ph == 2) ? 52 : 29;
            repeat (4) begin
                if ($urandom_range(9) == 0)
                    send_request(8'($urandom_range(255)), 1'b0, 1'b0);
                else
                    send_message($urandom_range(0, 6), 1'($urandom_range(1)));
            end
        end
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("sha512_hash_engine test passed");
        else
            $display("sha512_hash_engine test failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("sha512_hash_engine test failed");
        $finish;
    end
endmodule
